// File: rtl/crq_pkg.sv
// ----------------------------------------------------------------------------
// crq_pkg: shared types and constants for the coalescing request queue
// Field widths, opcode and status codes, and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package crq_pkg;

  // Field widths
  localparam int OP_W     = 2;
  localparam int CLIP_W   = 16;
  localparam int KEY_W    = CLIP_W + 1;
  localparam int FRAME_W  = 32;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 3;
  localparam int QDEPTH_W = 9;
  localparam int TOTAL_W  = 32;

  typedef enum logic [OP_W-1:0] {
    OP_SUBMIT = 2'd0,
    OP_POP    = 2'd1,
    OP_RESET  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_APPENDED       = 3'd0,
    ST_REPLACED       = 3'd1,
    ST_DROPPED_APPEND = 3'd2,
    ST_POPPED         = 3'd3,
    ST_POP_EMPTY      = 3'd4,
    ST_RESET          = 3'd5
  } stat_t;

  // Queue update performed by the datapath
  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_REPLACE,
    UPD_APPEND,
    UPD_POP,
    UPD_POP_EMPTY,
    UPD_CLEAR
  } upd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_CHECK,
    S_POP,
    S_FINISH
  } state_t;

  // One queue entry as stored in memory
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [FRAME_W-1:0]  focus;
    logic [FRAME_W-1:0]  source;
    logic [HANDLE_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0]     opcode;
    logic [CLIP_W-1:0]   clip_id;
    logic                clip_present;
    logic [FRAME_W-1:0]  focus_no;
    logic [FRAME_W-1:0]  source_no;
    logic [HANDLE_W-1:0] payload_handle;
  } req_t;

  typedef struct packed {
    stat_t               status;
    logic [CLIP_W-1:0]   out_clip_id;
    logic                out_clip_present;
    logic [FRAME_W-1:0]  out_focus_no;
    logic [FRAME_W-1:0]  out_source_no;
    logic [HANDLE_W-1:0] out_payload_handle;
    logic [QDEPTH_W-1:0] fill_level;
    logic [TOTAL_W-1:0]  dropped_total;
    logic [TOTAL_W-1:0]  submitted_total;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic load_req;
    logic scan_init;
    logic scan_read;
    logic pop_read;
    upd_t upd;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic present;
    logic scan_zero;
    logic match;
    logic empty;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/crq_ifs.sv
// ----------------------------------------------------------------------------
// crq_ifs: valid/ready channels of the coalescing request queue
// Request channel carries one command; response channel carries one result.
// ----------------------------------------------------------------------------
interface crq_in_if;
  import crq_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [CLIP_W-1:0]   clip_id;
  logic                clip_present;
  logic [FRAME_W-1:0]  focus_no;
  logic [FRAME_W-1:0]  source_no;
  logic [HANDLE_W-1:0] payload_handle;

  modport source (
    output valid, opcode, clip_id, clip_present, focus_no, source_no,
           payload_handle,
    input  ready
  );

  modport sink (
    input  valid, opcode, clip_id, clip_present, focus_no, source_no,
           payload_handle,
    output ready
  );
endinterface

interface crq_out_if;
  import crq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CLIP_W-1:0]   out_clip_id;
  logic                out_clip_present;
  logic [FRAME_W-1:0]  out_focus_no;
  logic [FRAME_W-1:0]  out_source_no;
  logic [HANDLE_W-1:0] out_payload_handle;
  logic [QDEPTH_W-1:0] fill_level;
  logic [TOTAL_W-1:0]  dropped_total;
  logic [TOTAL_W-1:0]  submitted_total;

  modport source (
    output valid, status, out_clip_id, out_clip_present, out_focus_no,
           out_source_no, out_payload_handle, fill_level, dropped_total,
           submitted_total,
    input  ready
  );

  modport sink (
    input  valid, status, out_clip_id, out_clip_present, out_focus_no,
           out_source_no, out_payload_handle, fill_level, dropped_total,
           submitted_total,
    output ready
  );
endinterface

// File: rtl/crq_datapath.sv
// ----------------------------------------------------------------------------
// crq_datapath: entry memory, ring pointers, counters and result register
// Executes one command per cycle from the controller and reports flags.
// ----------------------------------------------------------------------------
module crq_datapath #(
  parameter int NUM_ENTRIES = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  crq_pkg::req_t req_data,
  input  crq_pkg::cmd_t cmd,
  output crq_pkg::sts_t sts,
  output crq_pkg::rsp_t rsp_data,
  output logic          rsp_valid,
  input  logic          rsp_ready
);
  import crq_pkg::*;

  localparam int IDX_W = $clog2(NUM_ENTRIES);
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(NUM_ENTRIES);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(NUM_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

  // Ring position of an offset from the oldest entry
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= DEPTH_S) sum = sum - DEPTH_S;
    return sum[IDX_W-1:0];
  endfunction

  entry_t             mem [NUM_ENTRIES];
  req_t               req_r;
  entry_t             rd_data;
  logic [IDX_W-1:0]   head;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   scan;
  logic [TOTAL_W-1:0] dropped;
  logic [TOTAL_W-1:0] submitted;
  stat_t              res_status;

  logic [KEY_W-1:0]   req_key;
  logic [IDX_W-1:0]   head_inc;
  logic               full;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  assign req_key  = req_r.clip_present ? {1'b1, req_r.clip_id} : '0;
  assign head_inc = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign full     = (count == DEPTH_C);

  // Flags for the controller
  always_comb begin
    sts.op        = op_t'(req_r.opcode);
    sts.present   = req_r.clip_present;
    sts.scan_zero = (scan == '0);
    sts.match     = (rd_data.key == req_key) && (rd_data.focus == req_r.focus_no);
    sts.empty     = (count == '0);
    sts.out_free  = !rsp_valid || rsp_ready;
  end

  // Select read address: next older entry during a scan, else the oldest
  assign rd_addr = cmd.scan_read ? slot_of(head, scan - 1'b1) : head;

  // Select write port contents for replace and append
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = head;
    wr_data = '{key: req_key, focus: req_r.focus_no,
                source: req_r.source_no, payload: req_r.payload_handle};
    case (cmd.upd)
      UPD_REPLACE: begin
        wr_en         = 1'b1;
        wr_addr       = slot_of(head, scan);
        wr_data.key   = rd_data.key;
        wr_data.focus = rd_data.focus;
      end
      UPD_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = full ? head : slot_of(head, count);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.scan_read || cmd.pop_read) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Capture request, walk scan offset
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= req_data;
    end
    if (cmd.scan_init) begin
      scan <= count;
    end else if (cmd.scan_read) begin
      scan <= scan - 1'b1;
    end
  end

  // Update ring pointers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      dropped   <= '0;
      submitted <= '0;
    end else begin
      case (cmd.upd)
        UPD_REPLACE: begin
          submitted <= submitted + 1'b1;
        end
        UPD_APPEND: begin
          submitted <= submitted + 1'b1;
          if (full) begin
            head    <= head_inc;
            dropped <= dropped + 1'b1;
          end else begin
            count <= count + 1'b1;
          end
        end
        UPD_POP: begin
          head  <= head_inc;
          count <= count - 1'b1;
        end
        UPD_CLEAR: begin
          dropped <= dropped + TOTAL_W'(count);
          count   <= '0;
          head    <= '0;
        end
        default: begin
          head <= head;
        end
      endcase
    end
  end

  // Remember the outcome code
  always_ff @(posedge clk) begin
    case (cmd.upd)
      UPD_REPLACE:   res_status <= ST_REPLACED;
      UPD_APPEND:    res_status <= full ? ST_DROPPED_APPEND : ST_APPENDED;
      UPD_POP:       res_status <= ST_POPPED;
      UPD_POP_EMPTY: res_status <= ST_POP_EMPTY;
      UPD_CLEAR:     res_status <= ST_RESET;
      default:       res_status <= res_status;
    endcase
  end

  // Result register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_data.status          <= res_status;
      rsp_data.fill_level      <= QDEPTH_W'(count);
      rsp_data.dropped_total   <= dropped;
      rsp_data.submitted_total <= submitted;
      if (res_status == ST_POPPED) begin
        rsp_data.out_clip_id        <= rd_data.key[CLIP_W-1:0];
        rsp_data.out_clip_present   <= rd_data.key[KEY_W-1];
        rsp_data.out_focus_no       <= rd_data.focus;
        rsp_data.out_source_no      <= rd_data.source;
        rsp_data.out_payload_handle <= rd_data.payload;
      end else begin
        rsp_data.out_clip_id        <= '0;
        rsp_data.out_clip_present   <= 1'b0;
        rsp_data.out_focus_no       <= '0;
        rsp_data.out_source_no      <= '0;
        rsp_data.out_payload_handle <= '0;
      end
    end
  end

endmodule

// File: rtl/crq_ctrl.sv
// ----------------------------------------------------------------------------
// crq_ctrl: sequencer of the coalescing request queue
// Decodes the captured command, steps the newest-to-oldest key scan and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module crq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  crq_pkg::sts_t sts,
  output crq_pkg::cmd_t cmd
);
  import crq_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.upd       = UPD_NONE;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.op)
          OP_SUBMIT: begin
            if (sts.present) begin
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end else begin
              cmd.upd    = UPD_APPEND;
              state_next = S_FINISH;
            end
          end
          OP_POP: begin
            if (sts.empty) begin
              cmd.upd    = UPD_POP_EMPTY;
              state_next = S_FINISH;
            end else begin
              cmd.pop_read = 1'b1;
              state_next   = S_POP;
            end
          end
          OP_RESET: begin
            cmd.upd    = UPD_CLEAR;
            state_next = S_FINISH;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        // Fetch the next older entry, or append once all are checked
        if (sts.scan_zero) begin
          cmd.upd    = UPD_APPEND;
          state_next = S_FINISH;
        end else begin
          cmd.scan_read = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.match) begin
          cmd.upd    = UPD_REPLACE;
          state_next = S_FINISH;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_POP: begin
        cmd.upd    = UPD_POP;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // Wait for room in the result register
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/coalescing_request_queue.sv
// ----------------------------------------------------------------------------
// coalescing_request_queue: bounded request FIFO with coalescing
// Commands arrive on req (submit, pop, reset); one result per command leaves
// on rsp, except opcode 3, which is taken and produces nothing.
//
// A keyed submit scans queued entries newest to oldest and overwrites the
// first one whose clip id and focus frame match; otherwise it appends,
// dropping the oldest entry when full. Pop returns the oldest entry; reset
// discards all entries and counts them as dropped.
//
// After the transfer a command is decoded; a pop then reads the oldest entry,
// and a keyed submit alternates a read and a check of each entry until one
// matches or none is left; the result is then loaded into the result register
// once it is free; opcode 3 returns to idle after decode. One command is in
// work at a time. The scan is set by the single registered read port of the
// entry memory, which reads one entry before each check.
// req.ready is high only while no command is in work; a finished result may
// sit in the rsp register, so a stalled receiver blocks req only once the
// next result is ready. The rst input empties the queue and clears both counters.
// ----------------------------------------------------------------------------
module coalescing_request_queue #(
  parameter int NUM_ENTRIES = 256
) (
  input logic       clk,
  input logic       rst,
  crq_in_if.sink    req,
  crq_out_if.source rsp
);
  import crq_pkg::*;

  req_t req_data;
  rsp_t rsp_data;
  cmd_t cmd;
  sts_t sts;
  logic rsp_valid;

  // Pack request payload
  always_comb begin
    req_data.opcode         = req.opcode;
    req_data.clip_id        = req.clip_id;
    req_data.clip_present   = req.clip_present;
    req_data.focus_no       = req.focus_no;
    req_data.source_no      = req.source_no;
    req_data.payload_handle = req.payload_handle;
  end

  assign req.ready = cmd.in_ready;

  crq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  crq_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_data  (rsp_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready)
  );

  // Unpack result payload
  assign rsp.valid              = rsp_valid;
  assign rsp.status             = rsp_data.status;
  assign rsp.out_clip_id        = rsp_data.out_clip_id;
  assign rsp.out_clip_present   = rsp_data.out_clip_present;
  assign rsp.out_focus_no       = rsp_data.out_focus_no;
  assign rsp.out_source_no      = rsp_data.out_source_no;
  assign rsp.out_payload_handle = rsp_data.out_payload_handle;
  assign rsp.fill_level         = rsp_data.fill_level;
  assign rsp.dropped_total      = rsp_data.dropped_total;
  assign rsp.submitted_total    = rsp_data.submitted_total;

  // One command in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while a command is in work");

  // Result register is never overwritten before its transfer
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a pending result");

  // Pop only from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.upd == UPD_POP |-> !sts.empty)
    else $error("pop issued on an empty queue");

  // Scan never reads below the oldest entry
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_read |-> !sts.scan_zero)
    else $error("scan read past the oldest entry");

endmodule
